// ===== rtl/lpht_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the hash table.
`default_nettype none

package lpht_pkg;

    // Slot count; a power of two, so the home slot is the low address bits.
    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = IDX_W + 1;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int LIMIT_W  = 9;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = ADDR_W + SIZE_W;
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_LIMIT     = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed
    {
        logic load;       // capture transaction, start at home slot
        logic refuse;     // insert refused at load limit
        logic ins_step;   // insert: move to next slot
        logic ins_write;  // insert: store entry in free slot
        logic rd_probe;   // remove: read slot under probe
        logic probe_adv;  // remove: move to next slot
        logic miss;       // remove: key absent
        logic hit;        // remove: key found, open hole
        logic sh_rd;      // shift: read slot after scan pointer
        logic sh_move;    // shift: move read entry into hole
        logic free;       // release hole slot
        logic emit;       // load result register
    } lpht_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic is_remove;
        logic at_limit;
        logic used_cur;
        logic used_next;
        logic probe_end;
        logic key_match;
        logic stays;
    } lpht_stat_t;

endpackage

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear-probing address-to-size hash table.
//
// One transaction at a time. An insert steps over occupied slots from the home
// slot and stores the entry in the first free one; a refused insert stores
// nothing. A remove reads and compares slots from the home slot until the key
// matches or a free slot or a full probe ends it as a miss; after a hit, the
// backward shift scans the following occupied slots and the hole is then freed.
// Each compare needs a read state and a compare state because the single slot
// RAM has a registered read port; valid bits are flip-flops cleared at reset, so
// there is no clearing pass. A new transaction is taken once the previous result
// sits in the output register, whether or not that result has been taken yet.
`default_nettype none

module linear_probe_hash_table import lpht_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                command,
    input  wire logic [ADDR_W-1:0]   address,
    input  wire logic [SIZE_W-1:0]   block_size,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [STATUS_W-1:0] status,
    output logic      [SIZE_W-1:0]   found_size,
    output logic      [COUNT_W-1:0]  entry_count
);

    lpht_cmd_t  cmd;
    lpht_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpht_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .command     (command),
        .address     (address),
        .block_size  (block_size),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .found_size  (found_size),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

// ===== rtl/lpht_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lpht_datapath.sv =====
// Datapath: slot store, valid bits, probe/hole pointers, entry count and result register.
`default_nettype none

module lpht_datapath import lpht_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [LIMIT_W-1:0]   cfg_wdata,
    input  wire logic                 command,
    input  wire logic [ADDR_W-1:0]    address,
    input  wire logic [SIZE_W-1:0]    block_size,
    input  wire lpht_cmd_t            cmd,
    output lpht_stat_t                stat,
    output logic      [STATUS_W-1:0]  status,
    output logic      [SIZE_W-1:0]    found_size,
    output logic      [COUNT_W-1:0]   entry_count
);

    logic [SLOTS-1:0]   used_reg;
    logic [SLOTS-1:0]   used_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [LIMIT_W-1:0] limit_reg;

    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   hole_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [CNT_W-1:0]   n_reg;
    status_t            status_reg;
    logic [SIZE_W-1:0]  found_reg;

    status_t            status_out_reg;
    logic [SIZE_W-1:0]  found_out_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] rd_data;

    logic [IDX_W-1:0]   jn_idx;
    logic [ADDR_W-1:0]  rd_key;
    logic [SIZE_W-1:0]  rd_size;
    logic [IDX_W-1:0]   rd_home;
    logic [CMP_W-1:0]   count_cmp;

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        jn_idx    = j_reg + IDX_W'(1);
        rd_key    = rd_data[ENTRY_W-1:SIZE_W];
        rd_size   = rd_data[SIZE_W-1:0];
        rd_home   = rd_key[IDX_W-1:0];

        ram_we    = cmd.ins_write | cmd.sh_move;
        ram_waddr = cmd.sh_move ? hole_reg : idx_reg;
        ram_wdata = cmd.sh_move ? rd_data : {addr_reg, size_reg};
        ram_re    = cmd.rd_probe | cmd.sh_rd;
        ram_raddr = cmd.sh_rd ? jn_idx : idx_reg;

        count_cmp = CMP_W'(count_reg);

        stat.is_remove = (op_reg == CMD_REMOVE);
        stat.at_limit  = (count_cmp >= CMP_W'(limit_reg)) || (count_reg >= CNT_W'(SLOTS));
        stat.used_cur  = used_reg[idx_reg];
        stat.used_next = used_reg[jn_idx];
        stat.probe_end = (n_reg == CNT_W'(SLOTS));
        stat.key_match = (rd_key == addr_reg);
        // home cyclically in (hole, j]: entry keeps its place
        if (hole_reg <= j_reg)
        begin
            stat.stays = (rd_home > hole_reg) && (rd_home <= j_reg);
        end
        else
        begin
            stat.stays = (rd_home > hole_reg) || (rd_home <= j_reg);
        end

        used_next  = used_reg;
        count_next = count_reg;
        if (cmd.ins_write)
        begin
            used_next[idx_reg] = 1'b1;
            count_next         = count_reg + CNT_W'(1);
        end
        if (cmd.free)
        begin
            used_next[hole_reg] = 1'b0;
            count_next          = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(command);
            addr_reg   <= address;
            size_reg   <= block_size;
            idx_reg    <= address[IDX_W-1:0];
            n_reg      <= '0;
            status_reg <= STATUS_OK;
            found_reg  <= '0;
        end
        if (cmd.ins_step || cmd.probe_adv)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            n_reg   <= n_reg + CNT_W'(1);
        end
        if (cmd.refuse)
        begin
            status_reg <= STATUS_LIMIT;
        end
        if (cmd.miss)
        begin
            status_reg <= STATUS_NOT_FOUND;
        end
        if (cmd.hit)
        begin
            found_reg <= rd_size;
            hole_reg  <= idx_reg;
            j_reg     <= idx_reg;
            n_reg     <= '0;
        end
        if (cmd.sh_rd)
        begin
            j_reg <= jn_idx;
            n_reg <= n_reg + CNT_W'(1);
        end
        if (cmd.sh_move)
        begin
            hole_reg <= j_reg;
        end
        if (cmd.emit)
        begin
            status_out_reg <= status_reg;
            found_out_reg  <= found_reg;
            count_out_reg  <= count_cmp[COUNT_W-1:0];
        end
    end

    assign status      = status_out_reg;
    assign found_size  = found_out_reg;
    assign entry_count = count_out_reg;

    a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |-> !used_reg[idx_reg])
        else $error("insert writes an occupied slot");

    a_insert_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |-> (count_cmp < CMP_W'(limit_reg)))
        else $error("insert stored at load limit");

    a_free_used_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free |-> used_reg[hole_reg])
        else $error("release of a free slot");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

endmodule

`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
// Controller: sequences insert probe, remove probe, backward shift and result hand-off.
`default_nettype none

module lpht_ctrl import lpht_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire lpht_stat_t stat,
    output lpht_cmd_t       cmd
);

    typedef enum logic [8:0]
    {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_INSERT   = 9'b000000100,
        S_RM_READ  = 9'b000001000,
        S_RM_CMP   = 9'b000010000,
        S_SH_READ  = 9'b000100000,
        S_SH_CMP   = 9'b001000000,
        S_FREE     = 9'b010000000,
        S_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        out_free   = !out_valid_reg || !out_stall;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_remove)
                begin
                    state_next = S_RM_READ;
                end
                else if (stat.at_limit)
                begin
                    cmd.refuse = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (stat.used_cur && !stat.probe_end)
                begin
                    cmd.ins_step = 1'b1;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_RM_READ:
            begin
                if (stat.probe_end || !stat.used_cur)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (stat.key_match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_SH_READ;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_RM_READ;
                end
            end
            S_SH_READ:
            begin
                if (stat.probe_end || !stat.used_next)
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_CMP;
                end
            end
            S_SH_CMP:
            begin
                cmd.sh_move = !stat.stays;
                state_next  = S_SH_READ;
            end
            S_FREE:
            begin
                cmd.free   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwrites an untaken result");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("transaction captured outside idle");

    a_hit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> $past(cmd.rd_probe))
        else $error("key compared without a slot read");

    a_move_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_move |-> $past(cmd.sh_rd))
        else $error("shift moves an entry that was not read");

endmodule

`default_nettype wire

// ===== tb/sv/tb_linear_probe_hash_table.sv =====
// Self-checking testbench for linear_probe_hash_table: insert/remove traffic with a predicted table.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    typedef struct packed
    {
        status_t             status;
        logic [SIZE_W-1:0]   size;
        logic [COUNT_W-1:0]  count;
    } op_outcome_t;

    typedef enum int
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class alloc_table_scoreboard;
        logic [ADDR_W-1:0] slot_addr [SLOTS];
        logic [SIZE_W-1:0] slot_bytes [SLOTS];
        bit                slot_busy [SLOTS];
        int unsigned       entries;
        int unsigned       limit;
        int unsigned       errors;
        op_outcome_t       outcomes_due [$];

        function new();
            foreach (slot_busy[k])
            begin
                slot_busy[k] = 1'b0;
                slot_addr[k] = '0;
                slot_bytes[k] = '0;
            end
            entries = 0;
            limit = LIMIT_RESET;
            errors = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        // backward-shift deletion from the hole onwards
        function void close_gap(logic [IDX_W-1:0] hole);
            logic [IDX_W-1:0] j;
            logic [IDX_W-1:0] h;
            bit keep;
            j = hole;
            for (int n = 0; n < SLOTS; n++)
            begin
                j++;
                if (!slot_busy[j])
                    break;
                h = slot_addr[j][IDX_W-1:0];
                keep = (hole <= j) ? (h > hole && h <= j) : (h > hole || h <= j);
                if (!keep)
                begin
                    slot_addr[hole] = slot_addr[j];
                    slot_bytes[hole] = slot_bytes[j];
                    slot_busy[hole] = 1'b1;
                    hole = j;
                end
            end
            slot_busy[hole] = 1'b0;
        endfunction

        function void take_request(op_t cmd, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] sz);
            op_outcome_t got;
            logic [IDX_W-1:0] i;
            got.status = STATUS_OK;
            got.size = '0;
            i = addr[IDX_W-1:0];
            if (cmd == CMD_INSERT)
            begin
                if (entries >= limit || entries >= SLOTS)
                    got.status = STATUS_LIMIT;
                else
                begin
                    for (int n = 0; n < SLOTS && slot_busy[i]; n++)
                        i++;
                    slot_addr[i] = addr;
                    slot_bytes[i] = sz;
                    slot_busy[i] = 1'b1;
                    entries++;
                end
            end
            else
            begin
                got.status = STATUS_NOT_FOUND;
                for (int n = 0; n < SLOTS && slot_busy[i]; n++)
                begin
                    if (slot_addr[i] == addr)
                    begin
                        got.size = slot_bytes[i];
                        close_gap(i);
                        entries--;
                        got.status = STATUS_OK;
                        break;
                    end
                    i++;
                end
            end
            got.count = COUNT_W'(entries);
            outcomes_due.push_back(got);
        endfunction

        function bit pick_stored(inout logic [ADDR_W-1:0] key);
            int start;
            int k;
            start = $urandom_range(0, SLOTS - 1);
            for (int n = 0; n < SLOTS; n++)
            begin
                k = (start + n) % SLOTS;
                if (slot_busy[k])
                begin
                    key = slot_addr[k];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_reply(logic [STATUS_W-1:0] st, logic [SIZE_W-1:0] sz,
                         logic [COUNT_W-1:0] cnt);
            op_outcome_t want;
            if (outcomes_due.size() == 0)
            begin
                report($sformatf("unexpected transaction: status %0d size %0h count %0d",
                                 st, sz, cnt));
                return;
            end
            want = outcomes_due.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (sz !== want.size)
                report($sformatf("found_size %0h, expected %0h", sz, want.size));
            if (cnt !== want.count)
                report($sformatf("entry_count %0d, expected %0d", cnt, want.count));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   block_size;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   found_size;
    logic [COUNT_W-1:0]  entry_count;

    alloc_table_scoreboard sb;
    int          burst_left = 0;
    logic [11:0] stall_tick = '0;
    stall_mode_t stall_mode = STALL_NONE;

    linear_probe_hash_table dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .block_size  (block_size),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_size  (found_size),
        .entry_count (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[7:0] == 8'd0)
            stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
        case (stall_mode)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_LIGHT:   out_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY:   out_stall <= ($urandom_range(0, 1) == 0);
            default:       out_stall <= (stall_tick[3:0] < 4'd6);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reply(status, found_size, entry_count);
    end

    function automatic logic [ADDR_W-1:0] any_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic send(input op_t cmd, input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] sz);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= cmd;
        address <= a;
        block_size <= sz;
        do @(posedge clk); while (in_stall);
        sb.take_request(cmd, a, sz);
    endtask

    task automatic set_load_limit(input logic [LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.limit = v;
    endtask

    task automatic random_op(input int insert_pct, input int span, input logic [IDX_W-1:0] base);
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] sz;
        op_t cmd;
        a = any_address();
        if (span != 0)
            a[IDX_W-1:0] = base + IDX_W'($urandom_range(0, span - 1));
        sz = $urandom;
        case ($urandom_range(0, 9))
            0: sz = '0;
            1: sz = '1;
            default: ;
        endcase
        if ($urandom_range(1, 100) <= insert_pct)
        begin
            cmd = CMD_INSERT;
            if ($urandom_range(0, 19) == 0)
                void'(sb.pick_stored(a));
        end
        else
        begin
            cmd = CMD_REMOVE;
            if ($urandom_range(0, 3) != 0)
                void'(sb.pick_stored(a));
        end
        send(cmd, a, sz);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] a;
        int total;
        int n;
        int ins_pct;
        int span;
        logic [LIMIT_W-1:0] lim;

        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        command <= CMD_INSERT;
        address <= '0;
        block_size <= '0;
        out_stall <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, wrap-round chain, duplicates, shift on removal
        send(CMD_REMOVE, '0, '1);
        send(CMD_INSERT, '0, '0);
        send(CMD_INSERT, '1, '1);
        send(CMD_INSERT, 48'h0000_0000_01FF, 32'h1234_5678);
        send(CMD_INSERT, '1, 32'd5);
        send(CMD_INSERT, 48'h0000_0000_0100, 32'hA5A5_5A5A);
        send(CMD_REMOVE, '1, '0);
        send(CMD_REMOVE, '1, '1);
        send(CMD_REMOVE, '1, '0);
        send(CMD_REMOVE, 48'h0000_0000_0100, '0);
        send(CMD_REMOVE, 48'h0000_0000_01FF, '0);
        send(CMD_REMOVE, '0, '0);
        send(CMD_INSERT, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
        send(CMD_INSERT, 48'h5555_5555_5555, 32'hAAAA_AAAA);
        send(CMD_REMOVE, 48'h5555_5555_5555, '0);
        send(CMD_REMOVE, 48'hAAAA_AAAA_AAAA, '0);

        set_load_limit('0);
        send(CMD_INSERT, any_address(), $urandom);
        send(CMD_INSERT, '1, '1);
        send(CMD_REMOVE, any_address(), '0);

        set_load_limit(9'd1);
        send(CMD_INSERT, 48'h8000_0000_0001, 32'h8000_0000);
        send(CMD_INSERT, any_address(), $urandom);
        send(CMD_REMOVE, 48'h8000_0000_0001, '0);

        // fill to capacity, then refusals and a full-length miss
        set_load_limit(9'd256);
        for (int k = 0; k < SLOTS; k++)
        begin
            a = any_address();
            a[IDX_W-1:0] = IDX_W'(k);
            send(CMD_INSERT, a, $urandom);
        end
        send(CMD_INSERT, any_address(), $urandom);
        set_load_limit('1);
        send(CMD_INSERT, any_address(), $urandom);
        send(CMD_REMOVE, any_address(), '0);
        repeat (3)
        begin
            void'(sb.pick_stored(a));
            send(CMD_REMOVE, a, $urandom);
        end
        repeat (4)
            send(CMD_INSERT, any_address(), $urandom);

        total = 0;
        while (total < 560)
        begin
            n = $urandom_range(30, 80);
            case ($urandom_range(0, 7))
                0: lim = 9'd1;
                1: lim = $urandom_range(2, 16);
                2: lim = LIMIT_RESET;
                3: lim = 9'd256;
                4: lim = '1;
                5: lim = '0;
                default: lim = $urandom_range(0, 511);
            endcase
            set_load_limit(lim);
            ins_pct = $urandom_range(25, 80);
            span = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            a = any_address();
            repeat (n)
                random_op(ins_pct, span, a[IDX_W-1:0]);
            total += n;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout: %0d transactions still expected", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
